/* rtl/core/err_pkg.sv */
// shared types, constants and register codes for the elliptical radius raster
`timescale 1ns / 1ps

package err_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int CENTER_BITS = 24;
    localparam int SIZE_BITS   = 16;
    localparam int PIX_BITS    = 32;
    localparam int COEF_BITS   = 32;
    localparam int COEF_FRAC   = 28;
    localparam int DIGIT_BITS  = 16;
    localparam int Q_GUARD     = 34;
    localparam int SQ_IN_BITS  = 48;
    localparam int RAD_BITS    = 24;

    localparam logic [RAD_BITS-1:0]  RAD_MAX    = '1;
    localparam logic [COEF_BITS-1:0] COEF_ONE   = 32'h1000_0000;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 16'd1;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_COEF_XX      = 3'd2,
        REG_COEF_YY      = 3'd3,
        REG_COEF_XY      = 3'd4,
        REG_FRAME_WIDTH  = 3'd5,
        REG_FRAME_HEIGHT = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_XX,
        ST_YY,
        ST_XY,
        ST_ROOT,
        ST_DONE
    } rr_state_t;

    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_MUL,
        MAC_COEF
    } mac_phase_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic negate;
    } mac_cmd_t;

endpackage

/* rtl/core/err_mac.sv */
// shared digit multiplier that accumulates one signed term coef*a*b per start
`timescale 1ns / 1ps

module err_mac #(
    parameter int OFF_BITS = err_pkg::COORD_BITS_DEF + err_pkg::FRAC_BITS_DEF,
    parameter int Q_BITS   = 2 * OFF_BITS + err_pkg::Q_GUARD
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  err_pkg::mac_cmd_t             cmd,
    input  logic [OFF_BITS-1:0]           op_a,
    input  logic [OFF_BITS-1:0]           op_b,
    input  logic [err_pkg::COEF_BITS-1:0] coef_mag,
    output logic [Q_BITS-1:0]             acc,
    output logic                          done
);

    localparam int DIG    = err_pkg::DIGIT_BITS;
    localparam int ND1    = (OFF_BITS + DIG - 1) / DIG;
    localparam int ND2    = (2 * OFF_BITS + DIG - 1) / DIG;
    localparam int A_BITS = ND1 * DIG;
    localparam int P_BITS = ND2 * DIG;
    localparam int MB     = (OFF_BITS > err_pkg::COEF_BITS) ? OFF_BITS : err_pkg::COEF_BITS;
    localparam int KW     = $clog2(ND2);

    err_pkg::mac_phase_t phase_reg, phase_next;

    logic [A_BITS-1:0]             a_sr_reg;
    logic [OFF_BITS-1:0]           b_reg;
    logic [err_pkg::COEF_BITS-1:0] c_reg;
    logic                          neg_reg;
    logic [P_BITS-1:0]             p_reg;
    logic [Q_BITS-1:0]             q_reg;
    logic [KW-1:0]                 k_reg;
    logic                          done_reg;

    logic              mul_sel;
    logic              last_mul;
    logic              last_coef;
    logic [DIG-1:0]    digit;
    logic [MB-1:0]     opb;
    logic [DIG+MB-1:0] prod;
    logic [P_BITS-1:0] pp_p;
    logic [Q_BITS-1:0] pp_q;

    assign last_mul  = (k_reg == KW'(ND1 - 1));
    assign last_coef = (k_reg == KW'(ND2 - 1));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            err_pkg::MAC_IDLE:
            begin
                if (cmd.start)
                    phase_next = err_pkg::MAC_MUL;
            end
            err_pkg::MAC_MUL:
            begin
                if (last_mul)
                    phase_next = err_pkg::MAC_COEF;
            end
            err_pkg::MAC_COEF:
            begin
                if (last_coef)
                    phase_next = err_pkg::MAC_IDLE;
            end
            default: phase_next = err_pkg::MAC_IDLE;
        endcase
    end

    // operand steering
    always_comb
    begin
        mul_sel = 1'b0;
        unique case (phase_reg)
            err_pkg::MAC_MUL:  mul_sel = 1'b1;
            err_pkg::MAC_IDLE: mul_sel = 1'b0;
            err_pkg::MAC_COEF: mul_sel = 1'b0;
            default:           mul_sel = 1'b0;
        endcase
    end

    assign digit = mul_sel ? a_sr_reg[DIG-1:0] : p_reg[DIG-1:0];
    assign opb   = mul_sel ? MB'(b_reg) : MB'(c_reg);
    assign prod  = (DIG + MB)'(digit) * (DIG + MB)'(opb);
    // digit k sits at bit 16k of the operand
    assign pp_p  = P_BITS'(prod) << (k_reg * DIG);
    assign pp_q  = Q_BITS'(prod) << (k_reg * DIG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= err_pkg::MAC_IDLE;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == err_pkg::MAC_COEF) && last_coef;
            if (phase_reg == err_pkg::MAC_IDLE)
                k_reg <= '0;
            else if ((phase_reg == err_pkg::MAC_MUL && last_mul) || last_coef)
                k_reg <= '0;
            else
                k_reg <= k_reg + KW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == err_pkg::MAC_IDLE && cmd.start)
        begin
            a_sr_reg <= A_BITS'(op_a);
            b_reg    <= op_b;
            c_reg    <= coef_mag;
            neg_reg  <= cmd.negate;
            p_reg    <= '0;
            if (cmd.clear)
                q_reg <= '0;
        end
        else if (phase_reg == err_pkg::MAC_MUL)
        begin
            a_sr_reg <= a_sr_reg >> DIG;
            p_reg    <= p_reg + pp_p;
        end
        else if (phase_reg == err_pkg::MAC_COEF)
        begin
            p_reg <= p_reg >> DIG;
            q_reg <= neg_reg ? (q_reg - pp_q) : (q_reg + pp_q);
        end
    end

    assign acc  = q_reg;
    assign done = done_reg;

endmodule

/* rtl/core/err_isqrt.sv */
// bit-pair-per-cycle integer square root of a 48-bit value
`timescale 1ns / 1ps

module err_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [err_pkg::SQ_IN_BITS-1:0] value,
    output logic [err_pkg::RAD_BITS-1:0]   root,
    output logic                           done
);

    localparam int SW = err_pkg::SQ_IN_BITS;

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] res_reg;
    logic [SW-1:0] bit_reg;

    logic [SW:0]   trial;
    logic          take;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take  = ({1'b0, rem_reg} >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= value;
            res_reg <= '0;
            bit_reg <= {2'b01, {(SW-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial[SW-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = res_reg[err_pkg::RAD_BITS-1:0];
    assign done = done_reg;

endmodule

/* rtl/core/elliptical_radius_raster.sv */
// top level: raster counters, register file, term sequencer and result register
`timescale 1ns / 1ps

// Elliptical radius over a raster of pixels.
// Pixel words enter on pixel_value with pixel_valid / pixel_ready, one word per
// pixel in raster order; each gives one result word on radius, flux,
// negative_form and last_of_frame with result_valid / result_ready.
// Registers (center, three coefficients, frame size) are written over the APB
// port at byte address 4*index; prdata returns the addressed register.
// One pixel at a time: the three terms run in turn on one shared 16-bit digit
// multiplier, which forms the product of the two offsets digit by digit and
// then multiplies it by the coefficient; then the root finds its result one
// bit at a time. The root is skipped when the form is negative or saturates.
// The finished word sits in the result register; the next pixel is taken
// while it waits, and only the hand-over of the following result stalls
// until result_ready.
// Reset clears the counters, loads the register defaults and empties the
// result register.

module elliptical_radius_raster #(
    parameter int COORD_BITS = err_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = err_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [err_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [err_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [err_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  logic [err_pkg::PIX_BITS-1:0]      pixel_value,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [err_pkg::RAD_BITS-1:0]      radius,
    output logic [err_pkg::PIX_BITS-1:0]      flux,
    output logic                              negative_form,
    output logic                              last_of_frame
);

    localparam int OFF_BITS = COORD_BITS + FRAC_BITS;
    localparam int Q_BITS   = 2 * OFF_BITS + err_pkg::Q_GUARD;
    localparam int CB       = err_pkg::COEF_BITS;
    localparam int SB       = err_pkg::SIZE_BITS;
    localparam int SQ       = err_pkg::SQ_IN_BITS;
    localparam int WIDE     = 48;

    // register file
    logic [err_pkg::CENTER_BITS-1:0] center_x_reg, center_y_reg;
    logic [CB-1:0]                   coef_xx_reg, coef_yy_reg, coef_xy_reg;
    logic [SB-1:0]                   frame_width_reg, frame_height_reg;

    logic             apb_write;
    err_pkg::reg_idx_t reg_idx;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;
    assign reg_idx   = err_pkg::reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            err_pkg::REG_CENTER_X:     prdata = 32'(center_x_reg);
            err_pkg::REG_CENTER_Y:     prdata = 32'(center_y_reg);
            err_pkg::REG_COEF_XX:      prdata = coef_xx_reg;
            err_pkg::REG_COEF_YY:      prdata = coef_yy_reg;
            err_pkg::REG_COEF_XY:      prdata = coef_xy_reg;
            err_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            err_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // state and counters
    err_pkg::rr_state_t state_reg, state_next;

    logic [SB-1:0] column_count_reg, row_count_reg;

    logic accept;
    logic end_row, end_frame;

    assign accept    = pixel_valid && pixel_ready;
    assign end_row   = ({1'b0, column_count_reg} + 17'd1) >= {1'b0, frame_width_reg};
    assign end_frame = end_row &&
                       (({1'b0, row_count_reg} + 17'd1) >= {1'b0, frame_height_reg});

    // offsets from pixel center to ellipse center
    logic [31:0]             col_w, row_w;
    logic [WIDE-1:0]         cx_w, cy_w;
    logic [OFF_BITS-1:0]     px, py, cx, cy, dx_mag, dy_mag;
    logic                    dx_neg, dy_neg;

    assign col_w  = 32'(column_count_reg);
    assign row_w  = 32'(row_count_reg);
    assign px     = {col_w[COORD_BITS-1:0], 1'b1, {(FRAC_BITS-1){1'b0}}};
    assign py     = {row_w[COORD_BITS-1:0], 1'b1, {(FRAC_BITS-1){1'b0}}};
    assign cx_w   = WIDE'(center_x_reg);
    assign cy_w   = WIDE'(center_y_reg);
    assign cx     = cx_w[OFF_BITS-1:0];
    assign cy     = cy_w[OFF_BITS-1:0];
    assign dx_neg = px < cx;
    assign dy_neg = py < cy;
    assign dx_mag = dx_neg ? (cx - px) : (px - cx);
    assign dy_mag = dy_neg ? (cy - py) : (py - cy);

    // per-pixel working registers
    logic [OFF_BITS-1:0]           mx_reg, my_reg;
    logic                          sx_reg, sy_reg;
    logic [err_pkg::PIX_BITS-1:0]  pix_reg;
    logic                          last_reg;
    logic [err_pkg::RAD_BITS-1:0]  rad_reg;
    logic                          neg_reg;

    // result register
    logic                          result_valid_reg;
    logic [err_pkg::RAD_BITS-1:0]  radius_reg;
    logic [err_pkg::PIX_BITS-1:0]  flux_reg;
    logic                          negative_form_reg;
    logic                          last_of_frame_reg;

    // shared units
    err_pkg::mac_cmd_t   mac_cmd;
    logic [OFF_BITS-1:0] mac_a, mac_b;
    logic [CB-1:0]       mac_coef;
    logic [CB-1:0]       mac_mag;
    logic [Q_BITS-1:0]   q_acc;
    logic                mac_done;

    logic                          root_start;
    logic [SQ-1:0]                 root_in;
    logic [err_pkg::RAD_BITS-1:0]  root_out;
    logic                          root_done;

    logic out_load;

    err_mac #(
        .OFF_BITS (OFF_BITS),
        .Q_BITS   (Q_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mac_cmd),
        .op_a     (mac_a),
        .op_b     (mac_b),
        .coef_mag (mac_mag),
        .acc      (q_acc),
        .done     (mac_done)
    );

    err_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (root_in),
        .root  (root_out),
        .done  (root_done)
    );

    // form sign, overflow and root operand
    logic                 q_neg, q_sat;
    logic [Q_BITS+SQ-1:0] q_wide, q_shift;

    assign q_neg   = q_acc[Q_BITS-1];
    assign q_wide  = (Q_BITS + SQ)'(q_acc);
    assign q_shift = q_wide >> err_pkg::COEF_FRAC;
    assign q_sat   = !q_neg && ((q_shift >> SQ) != '0);
    assign root_in = q_shift[SQ-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            err_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = err_pkg::ST_PREP;
            end
            err_pkg::ST_PREP: state_next = err_pkg::ST_XX;
            err_pkg::ST_XX:
            begin
                if (mac_done)
                    state_next = err_pkg::ST_YY;
            end
            err_pkg::ST_YY:
            begin
                if (mac_done)
                    state_next = err_pkg::ST_XY;
            end
            err_pkg::ST_XY:
            begin
                if (mac_done)
                    state_next = (q_neg || q_sat) ? err_pkg::ST_DONE : err_pkg::ST_ROOT;
            end
            err_pkg::ST_ROOT:
            begin
                if (root_done)
                    state_next = err_pkg::ST_DONE;
            end
            err_pkg::ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                    state_next = err_pkg::ST_IDLE;
            end
            default: state_next = err_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pixel_ready    = 1'b0;
        mac_cmd.start  = 1'b0;
        mac_cmd.clear  = 1'b0;
        mac_cmd.negate = 1'b0;
        mac_a          = mx_reg;
        mac_b          = my_reg;
        mac_coef       = coef_xy_reg;
        root_start     = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            err_pkg::ST_IDLE: pixel_ready = 1'b1;
            err_pkg::ST_PREP:
            begin
                mac_cmd.start  = 1'b1;
                mac_cmd.clear  = 1'b1;
                mac_a          = mx_reg;
                mac_b          = mx_reg;
                mac_coef       = coef_xx_reg;
                mac_cmd.negate = coef_xx_reg[CB-1];
            end
            err_pkg::ST_XX:
            begin
                mac_cmd.start  = mac_done;
                mac_a          = my_reg;
                mac_b          = my_reg;
                mac_coef       = coef_yy_reg;
                mac_cmd.negate = coef_yy_reg[CB-1];
            end
            err_pkg::ST_YY:
            begin
                mac_cmd.start  = mac_done;
                mac_a          = mx_reg;
                mac_b          = my_reg;
                mac_coef       = coef_xy_reg;
                mac_cmd.negate = coef_xy_reg[CB-1] ^ sx_reg ^ sy_reg;
            end
            err_pkg::ST_XY:   root_start = mac_done && !q_neg && !q_sat;
            err_pkg::ST_ROOT: root_start = 1'b0;
            err_pkg::ST_DONE: out_load = !result_valid_reg || result_ready;
            default:          pixel_ready = 1'b0;
        endcase
    end

    assign mac_mag = mac_coef[CB-1] ? (CB'(0) - mac_coef) : mac_coef;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= err_pkg::ST_IDLE;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            result_valid_reg <= 1'b0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            coef_xx_reg      <= err_pkg::COEF_ONE;
            coef_yy_reg      <= err_pkg::COEF_ONE;
            coef_xy_reg      <= '0;
            frame_width_reg  <= err_pkg::SIZE_RESET;
            frame_height_reg <= err_pkg::SIZE_RESET;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                if (end_row)
                begin
                    column_count_reg <= '0;
                    row_count_reg    <= end_frame ? '0 : (row_count_reg + SB'(1));
                end
                else
                begin
                    column_count_reg <= column_count_reg + SB'(1);
                end
            end

            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            if (apb_write)
            begin
                unique case (reg_idx)
                    err_pkg::REG_CENTER_X:     center_x_reg     <= pwdata[23:0];
                    err_pkg::REG_CENTER_Y:     center_y_reg     <= pwdata[23:0];
                    err_pkg::REG_COEF_XX:      coef_xx_reg      <= pwdata;
                    err_pkg::REG_COEF_YY:      coef_yy_reg      <= pwdata;
                    err_pkg::REG_COEF_XY:      coef_xy_reg      <= pwdata;
                    err_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[15:0];
                    err_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[15:0];
                    default:                   center_x_reg     <= center_x_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mx_reg   <= dx_mag;
            my_reg   <= dy_mag;
            sx_reg   <= dx_neg;
            sy_reg   <= dy_neg;
            pix_reg  <= pixel_value;
            last_reg <= end_frame;
        end

        if (state_reg == err_pkg::ST_XY && mac_done)
        begin
            neg_reg <= q_neg;
            rad_reg <= q_sat ? err_pkg::RAD_MAX : '0;
        end
        else if (state_reg == err_pkg::ST_ROOT && root_done)
        begin
            rad_reg <= root_out;
        end

        if (out_load)
        begin
            radius_reg        <= rad_reg;
            flux_reg          <= pix_reg;
            negative_form_reg <= neg_reg;
            last_of_frame_reg <= last_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign radius        = radius_reg;
    assign flux          = flux_reg;
    assign negative_form = negative_form_reg;
    assign last_of_frame = last_of_frame_reg;

    // checks
    a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && negative_form |-> radius == '0)
        else $error("negative form word with nonzero radius");

    a_mac_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == err_pkg::ST_XX || state_reg == err_pkg::ST_YY ||
                      state_reg == err_pkg::ST_XY))
        else $error("term finished outside a term state");

    a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == err_pkg::ST_ROOT)
        else $error("root finished outside root state");

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> state_reg == err_pkg::ST_PREP)
        else $error("accepted word did not start a computation");

endmodule

/* test/testbench.sv */
// self-checking testbench for the elliptical radius raster block
`timescale 1ns / 1ps

module testbench;

    localparam int COORD_W = err_pkg::COORD_BITS_DEF;
    localparam int FRAC_W = err_pkg::FRAC_BITS_DEF;
    localparam int RAD_W = err_pkg::RAD_BITS;
    localparam int PIX_W = err_pkg::PIX_BITS;
    localparam int CTR_W = err_pkg::CENTER_BITS;
    localparam int COEF_W = err_pkg::COEF_BITS;
    localparam int SIZE_W = err_pkg::SIZE_BITS;
    localparam int SQ_W = err_pkg::SQ_IN_BITS;
    localparam int ADDR_W = err_pkg::APB_ADDR_BITS;
    localparam int DATA_W = err_pkg::APB_DATA_BITS;
    localparam int PIXEL_TARGET = 1000;
    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam int PRINT_CAP = 200;
    localparam logic [2:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [PIX_W-1:0] flux;
        logic             negative_form;
        logic             last_of_frame;
    } radius_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;
    logic pready;
    logic pixel_valid, pixel_ready;
    logic [PIX_W-1:0] pixel_value;
    logic result_valid, result_ready;
    logic [RAD_W-1:0] radius;
    logic [PIX_W-1:0] flux;
    logic negative_form, last_of_frame;

    // predictor copy of the registers and the raster position
    logic [CTR_W-1:0] ctr_x, ctr_y;
    logic signed [COEF_W-1:0] k_xx, k_yy, k_xy;
    logic [SIZE_W-1:0] cols_per_row, rows_per_frame;
    logic [SIZE_W-1:0] col_pos, row_pos;

    logic [PIX_W-1:0] pixel_backlog[$];
    radius_word_t radius_expect[$];
    int mismatch_count = 0;
    int pixels_queued = 0;
    int words_checked = 0;
    int quiet_cycles = 0;
    int unsigned send_wait = 0;
    int unsigned stall_left = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    bit jitter_on = 1'b0;
    bit pix_taken = 1'b0;

    elliptical_radius_raster dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .radius       (radius),
        .flux         (flux),
        .negative_form(negative_form),
        .last_of_frame(last_of_frame)
    );

    always #5 clk = ~clk;

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(16, 120);
        return $urandom_range(0, 3);
    endfunction

    // floor of the square root, one result bit at a time
    function automatic logic [RAD_W-1:0] root48(logic [SQ_W-1:0] v);
        logic [RAD_W-1:0] r;
        logic [SQ_W-1:0] t;
        r = '0;
        for (int b = RAD_W - 1; b >= 0; b--)
        begin
            t = SQ_W'(r | (RAD_W'(1) << b));
            if (t * t <= v)
                r = t[RAD_W-1:0];
        end
        return r;
    endfunction

    // radius word for the pixel at the current raster position, then advance
    function automatic radius_word_t trace_radius(logic [PIX_W-1:0] pix);
        radius_word_t word;
        logic [CTR_W-1:0] px, py;
        logic signed [127:0] dx, dy, wxx, wyy, wxy, form, scaled;
        logic row_done, frame_done;
        px = {col_pos[COORD_W-1:0], FRAC_W'(0)} | (CTR_W'(1) << (FRAC_W - 1));
        py = {row_pos[COORD_W-1:0], FRAC_W'(0)} | (CTR_W'(1) << (FRAC_W - 1));
        dx = $signed(128'(px)) - $signed(128'(ctr_x));
        dy = $signed(128'(py)) - $signed(128'(ctr_y));
        wxx = k_xx;
        wyy = k_yy;
        wxy = k_xy;
        form = wxx * dx * dx + wyy * dy * dy + wxy * dx * dy;
        word.flux = pix;
        word.negative_form = form[127];
        word.radius = '0;
        if (!form[127])
        begin
            scaled = form >>> err_pkg::COEF_FRAC;
            if (|scaled[127:SQ_W])
                word.radius = err_pkg::RAD_MAX;
            else
                word.radius = root48(scaled[SQ_W-1:0]);
        end
        // zero size acts as one; a counter past the size wraps here
        row_done = 17'(col_pos) + 17'd1 >= 17'(cols_per_row);
        frame_done = row_done && (17'(row_pos) + 17'd1 >= 17'(rows_per_frame));
        word.last_of_frame = frame_done;
        if (row_done)
        begin
            col_pos = '0;
            row_pos = frame_done ? '0 : row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
        return word;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            err_pkg::REG_CENTER_X:     ctr_x = data[CTR_W-1:0];
            err_pkg::REG_CENTER_Y:     ctr_y = data[CTR_W-1:0];
            err_pkg::REG_COEF_XX:      k_xx = data;
            err_pkg::REG_COEF_YY:      k_yy = data;
            err_pkg::REG_COEF_XY:      k_xy = data;
            err_pkg::REG_FRAME_WIDTH:  cols_per_row = data[SIZE_W-1:0];
            err_pkg::REG_FRAME_HEIGHT: rows_per_frame = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_settings(logic [CTR_W-1:0] cx, logic [CTR_W-1:0] cy,
                                  logic [COEF_W-1:0] cxx, logic [COEF_W-1:0] cyy,
                                  logic [COEF_W-1:0] cxy, logic [SIZE_W-1:0] w,
                                  logic [SIZE_W-1:0] h);
        apb_write(err_pkg::REG_CENTER_X, 32'(cx));
        apb_write(err_pkg::REG_CENTER_Y, 32'(cy));
        apb_write(err_pkg::REG_COEF_XX, cxx);
        apb_write(err_pkg::REG_COEF_YY, cyy);
        apb_write(err_pkg::REG_COEF_XY, cxy);
        apb_write(err_pkg::REG_FRAME_WIDTH, 32'(w));
        apb_write(err_pkg::REG_FRAME_HEIGHT, 32'(h));
        @(posedge clk);
    endtask

    // wait until every queued pixel has come back as a word
    task automatic settle();
        do
            @(negedge clk);
        while (words_checked < pixels_queued);
        repeat (10) @(posedge clk);
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] v);
        pixel_backlog.push_back(v);
        pixels_queued++;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size(int unsigned top);
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2: return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(1, top));
        endcase
    endfunction

    // mostly near the frame, sometimes anywhere
    function automatic logic [CTR_W-1:0] pick_center(logic [SIZE_W-1:0] size);
        int unsigned top;
        top = (int'(size) + 1) * 256 - 1;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return CTR_W'($urandom);
            default: return CTR_W'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_settings();
        logic [SIZE_W-1:0] w, h;
        logic [CTR_W-1:0] cx, cy;
        logic [COEF_W-1:0] cxx, cyy, cxy;
        int unsigned span;
        w = pick_size(12);
        h = pick_size(6);
        cx = pick_center(w);
        cy = pick_center(h);
        if ($urandom_range(0, 3) != 0)
        begin
            // positive definite form: |cxy| below both diagonal weights
            cxx = $urandom_range(32'h0100_0000, 32'h4000_0000);
            cyy = $urandom_range(32'h0100_0000, 32'h4000_0000);
            span = (cxx < cyy) ? cxx : cyy;
            cxy = $urandom_range(0, span - 1);
            if ($urandom_range(0, 1) != 0)
                cxy = -cxy;
        end
        else
        begin
            cxx = pick_coef();
            cyy = pick_coef();
            cxy = pick_coef();
        end
        write_settings(cx, cy, cxx, cyy, cxy, w, h);
    endtask

    // pixel driver
    always @(negedge clk)
    begin
        if (!pixel_valid || pix_taken)
        begin
            if (send_wait > 0)
            begin
                pixel_valid <= 1'b0;
                send_wait = send_wait - 1;
            end
            else if (pixel_backlog.size() > 0)
            begin
                pixel_valid <= 1'b1;
                pixel_value <= pixel_backlog.pop_front();
                send_wait = jitter_on ? pick_gap() : 0;
            end
            else
            begin
                pixel_valid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            if (jitter_on && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin : monitor
        radius_word_t want;
        if (rst_n)
        begin
            pix_taken <= pixel_valid && pixel_ready;
            if (pixel_valid && pixel_ready)
                radius_expect.push_back(trace_radius(pixel_value));
            if (result_valid && result_ready)
            begin
                words_checked++;
                if (radius_expect.size() == 0)
                begin
                    report_mismatch("unexpected word", flux, '0);
                end
                else
                begin
                    want = radius_expect.pop_front();
                    if (radius !== want.radius)
                        report_mismatch("radius", 32'(radius), 32'(want.radius));
                    if (flux !== want.flux)
                        report_mismatch("flux", flux, want.flux);
                    if (negative_form !== want.negative_form)
                        report_mismatch("negative_form", 32'(negative_form),
                                        32'(want.negative_form));
                    if (last_of_frame !== want.last_of_frame)
                        report_mismatch("last_of_frame", 32'(last_of_frame),
                                        32'(want.last_of_frame));
                end
            end
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready) || psel)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int phase;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pixel_valid = 1'b0;
        pixel_value = '0;
        result_ready = 1'b0;
        ctr_x = '0;
        ctr_y = '0;
        k_xx = err_pkg::COEF_ONE;
        k_yy = err_pkg::COEF_ONE;
        k_xy = '0;
        cols_per_row = err_pkg::SIZE_RESET;
        rows_per_frame = err_pkg::SIZE_RESET;
        col_pos = '0;
        row_pos = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // register defaults, pixel word extremes
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h5555_5555);
        queue_pixel(32'hAAAA_AAAA);

        // far center with the largest xx and xy weights and the most negative yy weight: saturation
        settle();
        write_settings('1, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd3, 16'd2);
        repeat (3) queue_pixel($urandom);

        // most negative diagonal weights, zero cross weight: negative form
        settle();
        write_settings('1, '1, 32'h8000_0000, 32'h8000_0000, '0, 16'd2, 16'd2);
        repeat (2) queue_pixel($urandom);

        // center on the first pixel, zero frame size, write past the register list
        settle();
        jitter_on = 1'b1;
        apb_write(REG_SPARE, '1);
        write_settings(24'h80, 24'h80, err_pkg::COEF_ONE, err_pkg::COEF_ONE, 32'h8000_0000,
                       '0, '0);
        repeat (3) queue_pixel($urandom);

        settle();
        write_settings(24'h180, 24'h100, 32'h1000_0000, 32'h0800_0000, 32'hF000_0000,
                       16'd4, 16'd3);
        repeat (5) queue_pixel($urandom);

        // shrink the frame while the counters sit past the new size
        settle();
        apb_write(err_pkg::REG_FRAME_WIDTH, 32'd1);
        apb_write(err_pkg::REG_FRAME_HEIGHT, 32'd1);
        @(posedge clk);
        repeat (3) queue_pixel($urandom);

        phase = 0;
        while (pixels_queued < PIXEL_TARGET)
        begin
            settle();
            jitter_on = ($urandom_range(0, 3) != 0) && (phase != 2);
            random_settings();
            // receiver holds off while pixels keep coming
            if (phase == 2)
                hold_asks++;
            repeat ($urandom_range(10, 50)) queue_pixel($urandom);
            phase++;
        end

        settle();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && radius_expect.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
